// ===== hw/rtl/rtco_pkg.sv =====
// Shared types and constants for the round-trip clock offset servo.
`default_nettype none
package rtco_pkg;

   localparam int STAMP_W     = 64;
   localparam int EXCH_W      = 4;
   localparam int EXCH_CNT_W  = 3;
   localparam int ROUND_W     = 7;
   localparam int CSR_DATA_W  = 7;

   localparam logic [EXCH_W-1:0]  EXCH_MAX    = 4'd8;
   localparam logic [EXCH_W-1:0]  EXCH_RESET  = 4'd5;
   localparam logic [ROUND_W-1:0] ROUND_MAX   = 7'd64;
   localparam logic [ROUND_W-1:0] ROUND_RESET = 7'd64;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   // room for fifo count plus every pipeline slot plus one new request
   localparam int OCC_W      = FIFO_CNT_W + 1;

   typedef enum logic [0:0] {
      CSR_EXCHANGES = 1'b0,
      CSR_ROUNDS    = 1'b1
   } csr_index_type;

   // one exchange as captured at the input register
   typedef struct packed {
      logic               start;
      logic [STAMP_W-1:0] prior;
      logic [STAMP_W-1:0] master;
      logic [STAMP_W-1:0] after;
   } exch_type;

   // kept exchange at the end of a round
   typedef struct packed {
      logic [STAMP_W-1:0] prior;
      logic [STAMP_W-1:0] after;
      logic [STAMP_W-1:0] master;
      logic [STAMP_W-1:0] rt;
      logic               first;
      logic               last;
   } best_type;

   // offset estimate of one round
   typedef struct packed {
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] neg;
      logic [STAMP_W-1:0] rt;
      logic [STAMP_W-1:0] moff;
      logic               zero;
      logic               first;
      logic               last;
   } est_type;

   // one result item
   typedef struct packed {
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] rt;
      logic [STAMP_W-1:0] moff;
      logic [STAMP_W-1:0] corr;
      logic               apply;
      logic               locked;
      logic               done;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rtco_select.sv =====
// Shortest round trip selection and exchange and round counting.
`default_nettype none
module rtco_select
   import rtco_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire exch_type              in_exch,
   input  wire logic [EXCH_W-1:0]     n_exch,
   input  wire logic [ROUND_W-1:0]    n_round,
   output logic                       ev_valid,
   output best_type                   ev
);

   localparam logic [STAMP_W-1:0] ALL_ONES = '1;

   logic [STAMP_W-1:0]    best_before_ff, best_before_in;
   logic [STAMP_W-1:0]    best_after_ff, best_after_in;
   logic [STAMP_W-1:0]    best_master_ff, best_master_in;
   logic [STAMP_W-1:0]    best_rt_ff, best_rt_in;
   logic [EXCH_CNT_W-1:0] exch_cnt_ff, exch_cnt_in;
   logic [ROUND_W-1:0]    round_cnt_ff, round_cnt_in;
   logic                  ev_valid_ff, ev_valid_in;
   best_type              ev_ff, ev_in;

   logic [STAMP_W-1:0]    base_before, base_after, base_master, base_rt;
   logic [EXCH_CNT_W-1:0] base_exch;
   logic [ROUND_W-1:0]    base_round;
   logic [STAMP_W-1:0]    cur_before, cur_after, cur_master, cur_rt, new_rt;
   logic                  round_end, session_end;

   always_comb begin
      // a new session starts from cleared state
      if (in_exch.start) begin
         base_before = '0;
         base_after  = ALL_ONES;
         base_master = '0;
         base_rt     = ALL_ONES;
         base_exch   = '0;
         base_round  = '0;
      end else begin
         base_before = best_before_ff;
         base_after  = best_after_ff;
         base_master = best_master_ff;
         base_rt     = best_rt_ff;
         base_exch   = exch_cnt_ff;
         base_round  = round_cnt_ff;
      end

      new_rt = in_exch.after - in_exch.prior;
      if (new_rt < base_rt) begin
         cur_before = in_exch.prior;
         cur_after  = in_exch.after;
         cur_master = in_exch.master;
         cur_rt     = new_rt;
      end else begin
         cur_before = base_before;
         cur_after  = base_after;
         cur_master = base_master;
         cur_rt     = base_rt;
      end

      round_end   = ({1'b0, base_exch} + 4'd1) >= n_exch;
      session_end = ({1'b0, base_round} + 8'd1) >= {1'b0, n_round};

      ev_in.prior  = cur_before;
      ev_in.after  = cur_after;
      ev_in.master = cur_master;
      ev_in.rt     = cur_rt;
      ev_in.first  = (base_round == '0);
      ev_in.last   = session_end;
      ev_valid_in  = in_valid && round_end;

      best_before_in = best_before_ff;
      best_after_in  = best_after_ff;
      best_master_in = best_master_ff;
      best_rt_in     = best_rt_ff;
      exch_cnt_in    = exch_cnt_ff;
      round_cnt_in   = round_cnt_ff;
      if (in_valid) begin
         if (!round_end) begin
            best_before_in = cur_before;
            best_after_in  = cur_after;
            best_master_in = cur_master;
            best_rt_in     = cur_rt;
            exch_cnt_in    = base_exch + 3'd1;
            round_cnt_in   = base_round;
         end else begin
            best_before_in = '0;
            best_after_in  = ALL_ONES;
            best_master_in = '0;
            best_rt_in     = ALL_ONES;
            exch_cnt_in    = '0;
            round_cnt_in   = session_end ? '0 : base_round + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_before_ff <= '0;
         best_after_ff  <= ALL_ONES;
         best_master_ff <= '0;
         best_rt_ff     <= ALL_ONES;
         exch_cnt_ff    <= '0;
         round_cnt_ff   <= '0;
         ev_valid_ff    <= 1'b0;
      end else begin
         best_before_ff <= best_before_in;
         best_after_ff  <= best_after_in;
         best_master_ff <= best_master_in;
         best_rt_ff     <= best_rt_in;
         exch_cnt_ff    <= exch_cnt_in;
         round_cnt_ff   <= round_cnt_in;
         ev_valid_ff    <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rtco_estimate.sv =====
// Midpoint, signed offset and master offset of the kept exchange, two stages.
`default_nettype none
module rtco_estimate
   import rtco_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     ev_valid,
   input  wire best_type ev,
   output logic          mid_valid,
   output logic          est_valid,
   output est_type       est
);

   typedef struct packed {
      logic [STAMP_W-1:0] mid;
      logic [STAMP_W-1:0] master;
      logic [STAMP_W-1:0] rt;
      logic [STAMP_W-1:0] moff;
      logic               first;
      logic               last;
   } mid_type;

   logic    mid_valid_ff, est_valid_ff;
   mid_type mid_ff, mid_in;
   est_type est_ff, est_in;

   always_comb begin
      // halves first so the sum cannot overflow, carry in when both are odd
      mid_in.mid    = {1'b0, ev.prior[STAMP_W-1:1]} + {1'b0, ev.after[STAMP_W-1:1]}
                      + {{(STAMP_W-1){1'b0}}, ev.prior[0] & ev.after[0]};
      mid_in.master = ev.master;
      mid_in.rt     = ev.rt;
      mid_in.moff   = ev.master - ev.prior;
      mid_in.first  = ev.first;
      mid_in.last   = ev.last;

      est_in.delta = mid_ff.mid - mid_ff.master;
      est_in.neg   = mid_ff.master - mid_ff.mid;
      est_in.zero  = (mid_ff.mid == mid_ff.master);
      est_in.rt    = mid_ff.rt;
      est_in.moff  = mid_ff.moff;
      est_in.first = mid_ff.first;
      est_in.last  = mid_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         est_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= ev_valid;
         est_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      est_ff <= est_in;
   end

   assign mid_valid = mid_valid_ff;
   assign est_valid = est_valid_ff;
   assign est       = est_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rtco_servo.sv =====
// Lock detection, latency accumulation and correction of the servo.
`default_nettype none
module rtco_servo
   import rtco_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    est_valid,
   input  wire est_type est,
   output logic         push_valid,
   output rsp_type      push_data
);

   typedef struct packed {
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] neg;
      logic [STAMP_W-1:0] rt;
      logic [STAMP_W-1:0] moff;
      logic [STAMP_W-1:0] sum;
      logic               lock;
      logic               first;
      logic               last;
   } servo_type;

   logic               lock_ff, lock_in;
   logic [STAMP_W-1:0] sum_ff, sum_in;
   logic               s4_valid_ff;
   servo_type          s4_ff, s4_in;

   logic [STAMP_W-1:0] base_sum, quarter, corr;
   logic               base_lock, round_up;

   always_comb begin
      // first round of a session sees cleared lock and latency
      base_lock = est.first ? 1'b0 : lock_ff;
      base_sum  = est.first ? '0 : sum_ff;
      lock_in   = lock_ff;
      sum_in    = sum_ff;
      s4_in.lock = base_lock | est.zero;
      s4_in.sum  = (!s4_in.lock && !est.first) ? base_sum + est.neg : base_sum;
      if (est_valid) begin
         lock_in = s4_in.lock;
         sum_in  = s4_in.sum;
      end
      s4_in.delta = est.delta;
      s4_in.neg   = est.neg;
      s4_in.rt    = est.rt;
      s4_in.moff  = est.moff;
      s4_in.first = est.first;
      s4_in.last  = est.last;

      // divide by 4 toward zero: floor, plus one for a negative inexact value
      quarter  = {{2{s4_ff.sum[STAMP_W-1]}}, s4_ff.sum[STAMP_W-1:2]};
      round_up = s4_ff.sum[STAMP_W-1] & (s4_ff.sum[1:0] != 2'b00);
      if (s4_ff.lock) begin
         corr = '0;
      end else if (s4_ff.first) begin
         corr = s4_ff.neg;
      end else begin
         corr = s4_ff.neg + quarter + {{(STAMP_W-1){1'b0}}, round_up};
      end

      push_data.delta  = s4_ff.delta;
      push_data.rt     = s4_ff.rt;
      push_data.moff   = s4_ff.moff;
      push_data.corr   = corr;
      push_data.apply  = !s4_ff.lock;
      push_data.locked = s4_ff.lock;
      push_data.done   = s4_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff     <= 1'b0;
         sum_ff      <= '0;
         s4_valid_ff <= 1'b0;
      end else begin
         lock_ff     <= lock_in;
         sum_ff      <= sum_in;
         s4_valid_ff <= est_valid;
      end
   end

   always_ff @(posedge clock) begin
      s4_ff <= s4_in;
   end

   assign push_valid = s4_valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rtco_fifo.sv =====
// Result queue that decouples the pipeline from the response channel.
`default_nettype none
module rtco_fifo
   import rtco_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire rsp_type               push_data,
   input  wire logic                  pop,
   output logic                       out_valid,
   output rsp_type                    out_data,
   output logic [FIFO_CNT_W-1:0]      count
);

   rsp_type                mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/round_trip_clock_offset_servo.sv =====
// Top level of the round-trip clock offset servo.
//
// Each request on the req_ channel is one timing exchange: local stamp before,
// master stamp and local stamp after, with req_tuser marking the first
// exchange of a new session. After every exchanges_per_round requests one
// response leaves on the rsp_ channel with the signed offset, round trip,
// master offset and correction; rsp_tlast marks the final round of a session.
// The csr_ port writes the two length registers; write them only while idle.
//
// Throughput is one request per cycle while req_tready is high. A round
// result appears on rsp_tvalid once the request that closes the round has
// passed the input, selection, midpoint, offset, servo accumulation and result
// queue registers. The best-exchange compare and latency sum are combinational.
// When the receiver stalls, results collect in an eight-entry queue and
// req_tready drops once queued plus in-flight requests would fill it.
// Reset is synchronous: it clears the kept exchange, counters, lock and
// latency sum, empties the queue and restores the lengths to 5 and 64.
`default_nettype none
module round_trip_clock_offset_servo
   import rtco_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request: tdata = local_before, master_stamp, local_after (low to high)
   input  wire logic [3*STAMP_W-1:0]     req_tdata,
   // tuser = start_session
   input  wire logic                     req_tuser,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // response: tdata = offset_delta, round_trip, master_offset, correction
   output logic [4*STAMP_W-1:0]          rsp_tdata,
   // tuser = apply_correction, locked (low to high)
   output logic [1:0]                    rsp_tuser,
   // tlast = session_done
   output logic                          rsp_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_wen,
   input  wire csr_index_type            csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic [EXCH_W-1:0]     exch_cfg_ff, exch_cfg_in;
   logic [ROUND_W-1:0]    round_cfg_ff, round_cfg_in;
   logic [EXCH_W-1:0]     n_exch;
   logic [ROUND_W-1:0]    n_round;

   logic                  s0_valid_ff, s0_valid_in;
   exch_type              s0_ff;
   logic                  ready_ff, ready_in;
   logic                  accept;

   logic                  ev_valid, mid_valid, est_valid, push_valid;
   best_type              ev;
   est_type               est;
   rsp_type               push_data, out_data;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0]      occupancy, bound;

   always_comb begin
      exch_cfg_in  = exch_cfg_ff;
      round_cfg_in = round_cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_EXCHANGES: exch_cfg_in  = csr_wdata[EXCH_W-1:0];
            CSR_ROUNDS:    round_cfg_in = csr_wdata[ROUND_W-1:0];
            default: ;
         endcase
      end

      // zero counts as one, overlarge values saturate
      if (exch_cfg_ff == '0) begin
         n_exch = 4'd1;
      end else if (exch_cfg_ff > EXCH_MAX) begin
         n_exch = EXCH_MAX;
      end else begin
         n_exch = exch_cfg_ff;
      end
      if (round_cfg_ff == '0) begin
         n_round = 7'd1;
      end else if (round_cfg_ff > ROUND_MAX) begin
         n_round = ROUND_MAX;
      end else begin
         n_round = round_cfg_ff;
      end

      accept      = req_tvalid && ready_ff;
      s0_valid_in = accept;
      occupancy   = OCC_W'(s0_valid_ff) + OCC_W'(ev_valid) + OCC_W'(mid_valid)
                    + OCC_W'(est_valid) + OCC_W'(push_valid);
      // upper bound on queued plus in-flight work next cycle, pops ignored
      bound       = OCC_W'(fifo_count) + occupancy + OCC_W'(accept);
      ready_in    = bound < OCC_W'(FIFO_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exch_cfg_ff  <= EXCH_RESET;
         round_cfg_ff <= ROUND_RESET;
         s0_valid_ff  <= 1'b0;
         ready_ff     <= 1'b0;
      end else begin
         exch_cfg_ff  <= exch_cfg_in;
         round_cfg_ff <= round_cfg_in;
         s0_valid_ff  <= s0_valid_in;
         ready_ff     <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_ff.start  <= req_tuser;
         s0_ff.prior  <= req_tdata[STAMP_W-1:0];
         s0_ff.master <= req_tdata[2*STAMP_W-1:STAMP_W];
         s0_ff.after  <= req_tdata[3*STAMP_W-1:2*STAMP_W];
      end
   end

   rtco_select u_select (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s0_valid_ff),
      .in_exch  (s0_ff),
      .n_exch   (n_exch),
      .n_round  (n_round),
      .ev_valid (ev_valid),
      .ev       (ev)
   );

   rtco_estimate u_estimate (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (ev_valid),
      .ev        (ev),
      .mid_valid (mid_valid),
      .est_valid (est_valid),
      .est       (est)
   );

   rtco_servo u_servo (
      .clock      (clock),
      .reset      (reset),
      .est_valid  (est_valid),
      .est        (est),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rtco_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign req_tready = ready_ff;
   assign rsp_tdata  = {out_data.corr, out_data.moff, out_data.rt, out_data.delta};
   assign rsp_tuser  = {out_data.locked, out_data.apply};
   assign rsp_tlast  = out_data.done;

   // queue never receives a result while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && fifo_count == FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

   // ready only with a free slot for every request that may still produce a result
   a_credit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (OCC_W'(fifo_count) + occupancy) < OCC_W'(FIFO_DEPTH))
      else $error("request accepted without queue room");

   // a locked round carries no correction
   a_locked_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_data.locked) |-> (!out_data.apply && out_data.corr == '0))
      else $error("correction issued while locked");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the round-trip clock offset servo: directed and random exchanges checked per round.
module tb;
   import rtco_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PRINT_LIMIT   = 50;
   localparam logic [STAMP_W-1:0] ONES = '1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [3*STAMP_W-1:0]  req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [4*STAMP_W-1:0]  rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wen    = 1'b0;
   csr_index_type         csr_index  = CSR_EXCHANGES;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   always #2 clock = ~clock;

   round_trip_clock_offset_servo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   typedef struct {
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] rt;
      logic [STAMP_W-1:0] moff;
      logic [STAMP_W-1:0] corr;
      logic               apply;
      logic               locked;
      logic               done;
   } round_result_type;

   round_result_type expected_rounds[$];

   int errors     = 0;
   int cycles     = 0;
   int stall_left = 0;
   bit no_idle    = 1'b0;

   // servo state as the block should hold it
   logic [STAMP_W-1:0]    kept_before;
   logic [STAMP_W-1:0]    kept_after;
   logic [STAMP_W-1:0]    kept_master;
   logic [STAMP_W-1:0]    lat_sum;
   logic [EXCH_CNT_W-1:0] exch_seen;
   logic [ROUND_W-1:0]    rounds_done;
   logic                  servo_locked;
   logic [EXCH_W-1:0]     len_exch;
   logic [ROUND_W-1:0]    len_rounds;

   function automatic logic [STAMP_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int draw_idle();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // overflow-safe midpoint of two stamps
   function automatic logic [STAMP_W-1:0] midpoint(input logic [STAMP_W-1:0] b,
                                                   input logic [STAMP_W-1:0] a);
      return (b >> 1) + (a >> 1) + ((b[0] & a[0]) ? 64'd1 : 64'd0);
   endfunction

   function automatic logic [STAMP_W-1:0] quarter_toward_zero(input logic [STAMP_W-1:0] x);
      logic [STAMP_W-1:0] mag;
      if (x[STAMP_W-1]) begin
         mag = 64'd0 - x;
         return 64'd0 - (mag >> 2);
      end
      return x >> 2;
   endfunction

   function automatic int exch_len();
      if (len_exch == 0) return 1;
      if (len_exch > EXCH_MAX) return int'(EXCH_MAX);
      return int'(len_exch);
   endfunction

   function automatic int round_len();
      if (len_rounds == 0) return 1;
      if (len_rounds > ROUND_MAX) return int'(ROUND_MAX);
      return int'(len_rounds);
   endfunction

   task automatic clear_round();
      kept_before = '0;
      kept_after  = ONES;
      kept_master = '0;
      exch_seen   = '0;
   endtask

   task automatic clear_session();
      clear_round();
      rounds_done  = '0;
      lat_sum      = '0;
      servo_locked = 1'b0;
   endtask

   task automatic predict_exchange(input logic start, input logic [STAMP_W-1:0] b,
                                   input logic [STAMP_W-1:0] m, input logic [STAMP_W-1:0] a);
      round_result_type   res;
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] neg;
      int                 n_ex;
      int                 n_rd;
      n_ex = exch_len();
      n_rd = round_len();
      if (start) clear_session();
      if (a - b < kept_after - kept_before) begin
         kept_before = b;
         kept_after  = a;
         kept_master = m;
      end
      if (exch_seen + 1 < n_ex) begin
         exch_seen = exch_seen + 3'd1;
         return;
      end
      delta = midpoint(kept_before, kept_after) - kept_master;
      if (delta == 0) servo_locked = 1'b1;
      res.corr  = '0;
      res.apply = 1'b0;
      if (!servo_locked) begin
         neg = 64'd0 - delta;
         if (rounds_done > 0) begin
            lat_sum  = lat_sum + neg;
            res.corr = neg + quarter_toward_zero(lat_sum);
         end else begin
            res.corr = neg;
         end
         res.apply = 1'b1;
      end
      res.delta  = delta;
      res.rt     = kept_after - kept_before;
      res.moff   = kept_master - kept_before;
      res.locked = servo_locked;
      res.done   = (rounds_done + 1 >= n_rd);
      expected_rounds.push_back(res);
      if (res.done) begin
         clear_session();
      end else begin
         clear_round();
         rounds_done = rounds_done + 7'd1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [STAMP_W-1:0] got,
                                  input logic [STAMP_W-1:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // hold the request until taken, then leave valid up unless a gap follows
   task automatic send_exchange(input logic start, input logic [STAMP_W-1:0] b,
                                input logic [STAMP_W-1:0] m, input logic [STAMP_W-1:0] a);
      int gap;
      req_tuser  <= start;
      req_tdata  <= {a, m, b};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_exchange(start, b, m, a);
      gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : draw_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain results and let exchanges without a result clear the pipeline first, then write the register
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_rounds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_EXCHANGES) len_exch = value[EXCH_W-1:0];
      else len_rounds = value;
   endtask

   always @(posedge clock) begin : check_results
      round_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rounds.size() == 0) begin
            report_mismatch("unexpected result delta", rsp_tdata[63:0], '0);
         end else begin
            want = expected_rounds.pop_front();
            if (rsp_tdata[63:0] !== want.delta)
               report_mismatch("offset_delta", rsp_tdata[63:0], want.delta);
            if (rsp_tdata[127:64] !== want.rt)
               report_mismatch("round_trip", rsp_tdata[127:64], want.rt);
            if (rsp_tdata[191:128] !== want.moff)
               report_mismatch("master_offset", rsp_tdata[191:128], want.moff);
            if (rsp_tdata[255:192] !== want.corr)
               report_mismatch("correction", rsp_tdata[255:192], want.corr);
            if (rsp_tuser[0] !== want.apply)
               report_mismatch("apply_correction", rsp_tuser[0], want.apply);
            if (rsp_tuser[1] !== want.locked)
               report_mismatch("locked", rsp_tuser[1], want.locked);
            if (rsp_tlast !== want.done)
               report_mismatch("session_done", rsp_tlast, want.done);
         end
      end
      if (no_idle) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left = draw_idle();
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stamps at the ends of the range under the reset lengths
   task automatic test_extremes();
      send_exchange(1'b1, ONES, '0, ONES);
      send_exchange(1'b0, '0, ONES, '0);
      send_exchange(1'b0, 64'd1, 64'h8000_0000_0000_0000, '0);
      send_exchange(1'b0, 64'h8000_0000_0000_0000, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF);
      send_exchange(1'b0, '0, '0, '0);
   endtask

   // a round where nothing beats the reset trip, a lock, a locked round, auto restart
   task automatic test_defaults_and_lock();
      write_register(CSR_EXCHANGES, 7'd2);
      write_register(CSR_ROUNDS, 7'd3);
      send_exchange(1'b1, 64'd1, 64'd5, 64'd0);
      send_exchange(1'b0, 64'd10, 64'd7, 64'd9);
      send_exchange(1'b0, 64'd3, 64'd5, 64'd7);
      send_exchange(1'b0, 64'd20, 64'd99, 64'd30);
      send_exchange(1'b0, 64'd100, '0, 64'd101);
      send_exchange(1'b0, 64'd200, '0, 64'd300);
      send_exchange(1'b0, 64'h8000_0000_0000_0001, 64'h1234, 64'h8000_0000_0000_0003);
      send_exchange(1'b0, ONES - 64'd1, 64'd5, 64'd2);
   endtask

   // clamped lengths, lengths shrunk mid-round and mid-session, restart mid-round
   task automatic test_register_lengths();
      write_register(CSR_EXCHANGES, 7'd0);
      write_register(CSR_ROUNDS, 7'd0);
      send_exchange(1'b1, 64'hFFFF_FFFF_0000_0000, '0, 64'hFFFF_FFFF_0000_1000);
      write_register(CSR_EXCHANGES, 7'd15);
      write_register(CSR_ROUNDS, 7'd127);
      send_exchange(1'b1, 64'd1000, 64'd900, 64'd1040);
      send_exchange(1'b0, 64'd2000, 64'd2100, 64'd2010);
      send_exchange(1'b0, 64'd3000, 64'd2990, 64'd3100);
      write_register(CSR_EXCHANGES, 7'd2);
      send_exchange(1'b0, 64'd4000, 64'd4003, 64'd4005);
      write_register(CSR_EXCHANGES, 7'd1);
      write_register(CSR_ROUNDS, 7'd1);
      send_exchange(1'b0, 64'd5000, 64'd4000, 64'd5500);
      write_register(CSR_EXCHANGES, 7'd4);
      write_register(CSR_ROUNDS, 7'd64);
      send_exchange(1'b0, 64'd10, 64'd10, 64'd11);
      send_exchange(1'b0, 64'd20, 64'd20, 64'd21);
      send_exchange(1'b1, 64'd300, 64'd250, 64'd390);
      send_exchange(1'b0, 64'd400, 64'd420, 64'd470);
      send_exchange(1'b0, 64'd500, 64'd520, 64'd560);
      send_exchange(1'b0, 64'd600, 64'd615, 64'd640);
   endtask

   function automatic logic [STAMP_W-1:0] pick_offset();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 54) begin
         v = $urandom_range(0, 20000) - 10000;
         return v;
      end
      if (r < 80) begin
         v = $urandom;
         return v;
      end
      return rand64();
   endfunction

   // mostly whole sessions with one clock offset per round, some noise and cut sessions
   task automatic run_random_phase(input int count);
      int                 sent;
      int                 len;
      int                 n_ex;
      int                 k;
      logic [STAMP_W-1:0] base;
      logic [STAMP_W-1:0] b;
      logic [STAMP_W-1:0] a;
      logic [STAMP_W-1:0] off;
      logic [STAMP_W-1:0] rt;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            send_exchange(1'($urandom_range(0, 1)), rand64(), rand64(), rand64());
            sent++;
         end else begin
            n_ex = exch_len();
            len  = n_ex * round_len();
            if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
            base = rand64();
            off  = '0;
            for (k = 0; k < len && sent < count; k++) begin
               if (k % n_ex == 0) off = pick_offset();
               rt = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 2000));
               b  = base + $urandom_range(0, 500);
               a  = b + rt;
               send_exchange(k == 0, b, midpoint(b, a) - off, a);
               sent++;
               base = a;
            end
         end
      end
   endtask

   task automatic test_random_sessions();
      int                    phase;
      logic [CSR_DATA_W-1:0] n_ex;
      logic [CSR_DATA_W-1:0] n_rd;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin n_ex = 7'd1;  n_rd = 7'd1;   end
            1: begin n_ex = 7'd8;  n_rd = 7'd64;  end
            2: begin n_ex = 7'd0;  n_rd = 7'd0;   end
            3: begin n_ex = 7'd15; n_rd = 7'd127; end
            default: begin
               n_ex = 7'($urandom_range(0, 15));
               n_rd = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 6));
            end
         endcase
         write_register(CSR_EXCHANGES, n_ex);
         write_register(CSR_ROUNDS, n_rd);
         no_idle = (phase == 5);
         run_random_phase(150);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      len_exch   = EXCH_RESET;
      len_rounds = ROUND_RESET;
      clear_session();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_defaults_and_lock();
      test_register_lengths();
      test_random_sessions();
      req_tvalid <= 1'b0;
      while (expected_rounds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/rtco_pkg.sv
hw/rtl/rtco_select.sv
hw/rtl/rtco_estimate.sv
hw/rtl/rtco_servo.sv
hw/rtl/rtco_fifo.sv
hw/rtl/round_trip_clock_offset_servo.sv
tb/tb.sv
